FILE: src/ssra_pkg.sv
// Package: types, constants and helpers shared by the swap slot allocator files.
`default_nettype none
package ssra_pkg;

  localparam int MAX_SLOTS  = 4096;
  localparam int SLOT_W     = $clog2(MAX_SLOTS);
  localparam int COUNT_W    = 16;
  localparam int ENTRY_W    = 32;
  localparam int SLOT_SHIFT = 8;
  localparam int CFG_W      = 13;
  localparam int LIM_W      = 32;

  // free-slot bitmap: one bit per slot, packed into words
  localparam int BMW       = 64;
  localparam int BIT_W     = $clog2(BMW);
  localparam int BM_WORDS  = MAX_SLOTS / BMW;
  localparam int BM_IDX_W  = $clog2(BM_WORDS);

  localparam logic [COUNT_W-1:0] COUNT_SAT   = 16'hffff;
  localparam logic [CFG_W-1:0]   CFG_RESET   = 13'd4096;

  localparam logic [1:0] MODE_ALLOC   = 2'd0;
  localparam logic [1:0] MODE_DUP     = 2'd1;
  localparam logic [1:0] MODE_RELEASE = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_NOMEM = 2'd1;
  localparam logic [1:0] STATUS_INVAL = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] entry;
  } in_payload_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [ENTRY_W-1:0] new_entry;
  } out_payload_t;

  typedef enum logic [1:0] {
    SEQ_CLEAR,
    SEQ_IDLE,
    SEQ_LOOKUP,
    SEQ_UPDATE
  } seq_state_t;

  // index of the lowest set bit; zero when none is set
  function automatic logic [BIT_W-1:0] ffs_word(input logic [BMW-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int i = BMW - 1; i >= 0; i--) begin
      if (v[i]) idx = BIT_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [BM_IDX_W-1:0] ffs_summary(input logic [BM_WORDS-1:0] v);
    logic [BM_IDX_W-1:0] idx;
    idx = '0;
    for (int i = BM_WORDS - 1; i >= 0; i--) begin
      if (v[i]) idx = BM_IDX_W'(i);
    end
    return idx;
  endfunction

endpackage
`default_nettype wire

FILE: src/swap_slot_refcount_allocator.sv
// Top level: swap slot reference-count table with lowest-free-slot allocation.
`default_nettype none
// A request is taken when start is high and busy is low. Its result shows on
// out_data for one cycle, marked by out_valid, after the LOOKUP and UPDATE
// states; busy is high in those states and a new request may start in the
// cycle the result shows, so the block takes no new request while one is in
// flight. That is set by the read-modify-write through the count RAM and
// the free-slot bitmap RAM, each with a registered read. The receiver
// cannot stall: take each result in its cycle. After reset a clearing pass
// over all MAX_SLOTS (4096) slots zeroes the count RAM and marks every slot
// but slot 0 free; busy stays high throughout. cfg_we may be written at any
// time but is meant to change only while the block is idle.
module swap_slot_refcount_allocator (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output      logic                      busy,
  input  wire ssra_pkg::in_payload_t     in_data,
  output      logic                      out_valid,
  output      ssra_pkg::out_payload_t    out_data,
  input  wire logic                      cfg_we,
  input  wire logic [ssra_pkg::CFG_W-1:0] cfg_wdata
);
  import ssra_pkg::*;

  logic [COUNT_W-1:0] cnt_mem [MAX_SLOTS];
  logic [BMW-1:0]     bm_mem  [BM_WORDS];

  seq_state_t         state_r, state_nxt;
  logic [CFG_W-1:0]   slot_count_r;
  logic [SLOT_W-1:0]  clr_idx_r, clr_idx_nxt;
  logic [BM_WORDS-1:0] sum_r, sum_nxt;
  in_payload_t        req_r, req_nxt;
  logic [BM_IDX_W-1:0] word_r, word_nxt;
  logic               any_r, any_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_payload_t       out_data_r, out_data_nxt;

  logic [COUNT_W-1:0] cnt_q;
  logic [BMW-1:0]     bm_q;

  logic               cnt_we, bm_we;
  logic [SLOT_W-1:0]  cnt_waddr, cnt_raddr;
  logic [COUNT_W-1:0] cnt_wdata;
  logic [BM_IDX_W-1:0] bm_waddr, bm_raddr;
  logic [BMW-1:0]     bm_wdata;

  logic [LIM_W-1:0]   lim;
  logic [ENTRY_W-SLOT_SHIFT-1:0] req_slot;
  logic               req_slot_ok;
  logic [SLOT_W-1:0]  req_idx;
  logic [BIT_W-1:0]   alloc_bit;
  logic [SLOT_W-1:0]  alloc_slot;
  logic [BMW-1:0]     bm_clr_word;
  logic [BMW-1:0]     bm_set_word;
  logic [BMW-1:0]     bit_mask;

  // slot limit is min(slot_count, MAX_SLOTS)
  assign lim = (LIM_W'(slot_count_r) > LIM_W'(MAX_SLOTS)) ? LIM_W'(MAX_SLOTS)
                                                           : LIM_W'(slot_count_r);
  assign req_slot    = req_r.entry[ENTRY_W-1:SLOT_SHIFT];
  assign req_slot_ok = (req_slot != '0) && (LIM_W'(req_slot) < lim);
  assign req_idx     = req_r.entry[SLOT_SHIFT +: SLOT_W];

  assign alloc_bit   = ffs_word(bm_q);
  assign alloc_slot  = {word_r, alloc_bit};
  assign bm_clr_word = bm_q & ~(BMW'(1) << alloc_bit);
  assign bit_mask    = BMW'(1) << req_r.entry[SLOT_SHIFT +: BIT_W];
  assign bm_set_word = bm_q | bit_mask;

  assign busy      = (state_r != SEQ_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SEQ_CLEAR:  if (clr_idx_r == SLOT_W'(MAX_SLOTS - 1)) state_nxt = SEQ_IDLE;
      SEQ_IDLE:   if (start) state_nxt = SEQ_LOOKUP;
      SEQ_LOOKUP: state_nxt = SEQ_UPDATE;
      SEQ_UPDATE: state_nxt = SEQ_IDLE;
      default:    state_nxt = SEQ_CLEAR;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    clr_idx_nxt   = clr_idx_r;
    sum_nxt       = sum_r;
    req_nxt       = req_r;
    word_nxt      = word_r;
    any_nxt       = any_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cnt_we        = 1'b0;
    cnt_waddr     = req_idx;
    cnt_wdata     = '0;
    cnt_raddr     = req_idx;
    bm_we         = 1'b0;
    bm_waddr      = word_r;
    bm_wdata      = bm_q;
    bm_raddr      = word_r;

    case (state_r)
      SEQ_CLEAR: begin
        cnt_we      = 1'b1;
        cnt_waddr   = clr_idx_r;
        cnt_wdata   = '0;
        clr_idx_nxt = clr_idx_r + SLOT_W'(1);
        if (clr_idx_r[SLOT_W-1:BM_IDX_W] == '0) begin
          bm_we    = 1'b1;
          bm_waddr = clr_idx_r[BM_IDX_W-1:0];
          // slot 0 is reserved: never free
          bm_wdata = (clr_idx_r == '0) ? ~BMW'(1) : '1;
        end
      end
      SEQ_IDLE: begin
        if (start) req_nxt = in_data;
      end
      SEQ_LOOKUP: begin
        if (req_r.mode == MODE_ALLOC) begin
          word_nxt = ffs_summary(sum_r);
          any_nxt  = |sum_r;
        end else begin
          word_nxt = req_r.entry[SLOT_SHIFT + BIT_W +: BM_IDX_W];
          any_nxt  = 1'b0;
        end
        bm_raddr  = word_nxt;
        cnt_raddr = req_idx;
      end
      SEQ_UPDATE: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: STATUS_OK, new_entry: '0};
        case (req_r.mode)
          MODE_ALLOC: begin
            if (any_r && (LIM_W'(alloc_slot) < lim)) begin
              cnt_we         = 1'b1;
              cnt_waddr      = alloc_slot;
              cnt_wdata      = COUNT_W'(1);
              bm_we          = 1'b1;
              bm_wdata       = bm_clr_word;
              sum_nxt[word_r] = |bm_clr_word;
              out_data_nxt.new_entry = ENTRY_W'(alloc_slot) << SLOT_SHIFT;
            end else begin
              out_data_nxt.status = STATUS_NOMEM;
            end
          end
          MODE_DUP: begin
            if (!req_slot_ok || cnt_q == '0 || cnt_q == COUNT_SAT) begin
              out_data_nxt.status = STATUS_INVAL;
            end else begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_q + COUNT_W'(1);
            end
          end
          MODE_RELEASE: begin
            if (req_slot_ok && cnt_q != '0) begin
              cnt_we    = 1'b1;
              cnt_wdata = cnt_q - COUNT_W'(1);
              // last reference gone: hand the slot back to the bitmap
              if (cnt_q == COUNT_W'(1)) begin
                bm_we           = 1'b1;
                bm_wdata        = bm_set_word;
                sum_nxt[word_r] = 1'b1;
              end
            end
          end
          default: out_data_nxt.status = STATUS_INVAL;
        endcase
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk) begin
    if (bm_we) bm_mem[bm_waddr] <= bm_wdata;
    bm_q <= bm_mem[bm_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SEQ_CLEAR;
      clr_idx_r    <= '0;
      sum_r        <= '1;
      slot_count_r <= CFG_RESET;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      sum_r       <= sum_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) slot_count_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    word_r     <= word_nxt;
    any_r      <= any_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule
`default_nettype wire

FILE: src/ssra_checker.sv
// Checker: port-level assertions for the swap slot allocator, bound to the top level.
`default_nettype none
module ssra_checker (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire ssra_pkg::out_payload_t out_data,
  input wire logic                   out_valid
);
  import ssra_pkg::*;

  // a result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // a transfer makes the block busy in the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  // results show only once the block is free again
  a_idle_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while busy");

  // failed requests return a zero entry
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != STATUS_OK) |-> (out_data.new_entry == '0))
    else $error("non-zero entry on failed request");

  // an allocated entry has a clear low byte and a non-zero slot
  a_entry_format: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.new_entry != '0) |->
      (out_data.new_entry[SLOT_SHIFT-1:0] == '0 && out_data.status == STATUS_OK))
    else $error("malformed allocated entry");

endmodule

bind swap_slot_refcount_allocator ssra_checker u_ssra_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_data  (out_data),
  .out_valid (out_valid)
);
`default_nettype wire

FILE: sim/tb_top.sv
// Testbench for the swap slot allocator: directed table, reference stacking, fill and random phases.
`timescale 1ns / 100ps
module tb_top;
  import ssra_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int         N_PHASES    = 11;
  localparam int         PHASE_ITEMS = 50;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [CFG_W-1:0]   cfg_val;
    logic [1:0]         mode;
    logic [ENTRY_W-1:0] entry;
    logic               typed;
    logic [1:0]         status;
    logic [ENTRY_W-1:0] new_entry;
  } dir_row_t;

  localparam int N_ROWS = 26;

  // typed rows carry the result read straight off the behaviour; the rest use the predictor
  dir_row_t dir_rows [N_ROWS] = '{
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0100},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'hffff_ffff, 1'b1, STATUS_OK,    32'h0000_0200},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_01ff, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_0000, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'hffff_ffff, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_1000, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'hffff_ffff, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'h0000_1000, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_UNUSED,  32'h0000_0100, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'h0000_0100, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'h0000_01aa, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_0100, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b1, STATUS_OK,    32'h0000_0100},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h000f_ff00, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0010_0000, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h5a5a_5a5a, 1'b0, STATUS_OK,    32'h0000_0000},
    '{ROW_CFG, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b0, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b1, STATUS_NOMEM, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_0100, 1'b1, STATUS_INVAL, 32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_RELEASE, 32'h0000_0100, 1'b1, STATUS_OK,    32'h0000_0000},
    '{ROW_CFG, 13'd1,    MODE_ALLOC,   32'h0000_0000, 1'b0, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b1, STATUS_NOMEM, 32'h0000_0000},
    '{ROW_CFG, 13'd8191, MODE_ALLOC,   32'h0000_0000, 1'b0, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_DUP,     32'h0000_01ff, 1'b0, STATUS_OK,    32'h0000_0000},
    '{ROW_REQ, 13'd0,    MODE_ALLOC,   32'h0000_0000, 1'b0, STATUS_OK,    32'h0000_0000}
  };

  logic [CFG_W-1:0] phase_limits [N_PHASES] = '{
    13'd8, 13'd1024, 13'd3, 13'd4096, 13'd2, 13'd8191, 13'd16, 13'd0, 13'd64, 13'd1, 13'd4096
  };

  logic             clk = 1'b0;
  logic             rst_n;
  logic             start;
  logic             busy;
  in_payload_t      in_data;
  logic             out_valid;
  out_payload_t     out_data;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  // predictor state
  logic [COUNT_W-1:0] slot_refs [MAX_SLOTS];
  logic [CFG_W-1:0]   slot_cfg;
  logic [ENTRY_W-1:0] last_alloc;

  out_payload_t pending_results [$];
  int           err_count;

  swap_slot_refcount_allocator u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic out_payload_t refcount_predict(input in_payload_t req);
    out_payload_t res;
    int unsigned  lim;
    logic [23:0]  slot;
    bit           in_rng;
    res.status    = STATUS_OK;
    res.new_entry = '0;
    lim    = (slot_cfg > MAX_SLOTS) ? MAX_SLOTS : slot_cfg;
    slot   = 24'(req.entry >> SLOT_SHIFT);
    in_rng = (slot != 0) && (slot < lim);
    case (req.mode)
      MODE_ALLOC: begin
        res.status = STATUS_NOMEM;
        for (int s = 1; s < lim; s++) begin
          if (slot_refs[s] == '0) begin
            slot_refs[s]  = 16'd1;
            res.new_entry = ENTRY_W'(s) << SLOT_SHIFT;
            res.status    = STATUS_OK;
            break;
          end
        end
      end
      MODE_DUP: begin
        if (!in_rng) begin
          res.status = STATUS_INVAL;
        end else if (slot_refs[slot] == '0 || slot_refs[slot] == COUNT_SAT) begin
          res.status = STATUS_INVAL;
        end else begin
          slot_refs[slot] = slot_refs[slot] + 16'd1;
        end
      end
      MODE_RELEASE: begin
        if (in_rng) begin
          if (slot_refs[slot] != '0) slot_refs[slot] = slot_refs[slot] - 16'd1;
        end
      end
      default: res.status = STATUS_INVAL;
    endcase
    return res;
  endfunction

  // hold start and the payload until the transfer, then queue what it must produce
  task automatic send_req(input logic [1:0] mode, input logic [ENTRY_W-1:0] entry,
                          input bit typed, input out_payload_t typed_res);
    in_payload_t  p;
    out_payload_t r;
    p.mode  = mode;
    p.entry = entry;
    start   <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = refcount_predict(p);
    if (mode == MODE_ALLOC && r.status == STATUS_OK) last_alloc = r.new_entry;
    pending_results.push_back(typed ? typed_res : r);
  endtask

  task automatic hold_off(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain;
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_limit(input logic [CFG_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    slot_cfg   = v;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        err_count++;
        $display("%0t unexpected result: status %0d entry %h", $time,
                 out_data.status, out_data.new_entry);
      end else begin
        if (out_data.status !== pending_results[0].status ||
            out_data.new_entry !== pending_results[0].new_entry) begin
          err_count++;
          $display("%0t mismatch: expected status %0d entry %h, got status %0d entry %h",
                   $time, pending_results[0].status, pending_results[0].new_entry,
                   out_data.status, out_data.new_entry);
        end
        void'(pending_results.pop_front());
      end
    end
  end

  initial begin
    #40_000_000;
    $display("[swap_slot_refcount_allocator] ERROR");
    $finish;
  end

  initial begin
    out_payload_t     typed_res;
    int unsigned      lim;
    int unsigned      hi;
    int               pick;
    int               bnd;
    logic [1:0]       mode;
    logic [23:0]      slot;
    logic [ENTRY_W-1:0] entry;
    bit               idle_on;

    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_data   <= '0;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    err_count  = 0;
    last_alloc = 32'h0000_0100;
    slot_cfg   = CFG_RESET;
    foreach (slot_refs[i]) slot_refs[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    // clearing pass runs with busy high; send_req waits it out
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        drain();
        write_limit(dir_rows[i].cfg_val);
      end else begin
        typed_res.status    = dir_rows[i].status;
        typed_res.new_entry = dir_rows[i].new_entry;
        send_req(dir_rows[i].mode, dir_rows[i].entry, dir_rows[i].typed, typed_res);
      end
    end

    // stack references on slot 1, step back and add again
    drain();
    write_limit(13'd4096);
    typed_res = '0;
    repeat (3) send_req(MODE_DUP, 32'h0000_0100, 1'b0, typed_res);
    send_req(MODE_DUP, 32'h0000_01ff, 1'b0, typed_res);
    send_req(MODE_RELEASE, 32'h0000_0100, 1'b0, typed_res);
    send_req(MODE_DUP, 32'h0000_0100, 1'b0, typed_res);
    send_req(MODE_DUP, 32'h0000_0100, 1'b0, typed_res);

    // exhaust a small limit, then raise it past the table size
    drain();
    write_limit(13'd64);
    repeat (70) send_req(MODE_ALLOC, $urandom, 1'b0, typed_res);
    drain();
    write_limit(13'd8191);
    send_req(MODE_DUP, 32'h0003_ff00, 1'b0, typed_res);
    send_req(MODE_ALLOC, 32'h0000_0000, 1'b0, typed_res);
    send_req(MODE_DUP, 32'h000f_ffff, 1'b0, typed_res);
    send_req(MODE_RELEASE, 32'h0003_ff00, 1'b0, typed_res);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      drain();
      write_limit(phase_limits[ph]);
      lim     = (slot_cfg > MAX_SLOTS) ? MAX_SLOTS : slot_cfg;
      hi      = (lim < 40) ? lim + 1 : 40;
      idle_on = (ph < N_PHASES - 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 30)      mode = MODE_ALLOC;
        else if (pick < 65) mode = MODE_DUP;
        else if (pick < 95) mode = MODE_RELEASE;
        else                mode = MODE_UNUSED;
        pick = $urandom_range(0, 99);
        if (pick < 25) begin
          entry = last_alloc | ENTRY_W'($urandom_range(0, 255));
        end else if (pick < 75) begin
          slot  = 24'($urandom_range(0, hi));
          entry = {slot, 8'($urandom)};
        end else if (pick < 90) begin
          entry = $urandom;
        end else begin
          // straddle the top of the valid range
          bnd   = int'(lim) - int'($urandom_range(0, 1));
          if (bnd < 0) bnd = 0;
          slot  = 24'(bnd);
          entry = {slot, 8'($urandom)};
        end
        send_req(mode, entry, 1'b0, typed_res);
        if (k == PHASE_ITEMS / 2) begin
          drain();
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
          hold_off($urandom_range(1, 16));
        end
      end
    end

    drain();
    repeat (10) @(posedge clk);
    if (pending_results.size() != 0) begin
      err_count++;
      $display("%0t %0d results never arrived", $time, pending_results.size());
    end
    if (err_count == 0) begin
      $display("[swap_slot_refcount_allocator] OK");
    end else begin
      $display("[swap_slot_refcount_allocator] ERROR");
    end
    $finish;
  end

endmodule

FILE: swap_slot_refcount_allocator.f
src/ssra_pkg.sv
src/swap_slot_refcount_allocator.sv
src/ssra_checker.sv
sim/tb_top.sv
